FILE: rtl/akc_pkg.sv
`timescale 1ns / 1ps
// Types and constants shared by the autokey cipher engine.
package akc_pkg;

  localparam int unsigned LETTER_W       = 5;
  localparam int unsigned ALPHA_N        = 26;
  localparam int unsigned HALF_N         = 13;
  localparam int unsigned MAX_PRIMER_DEF = 32;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned CFG_DATA_W     = 2;

  typedef enum logic [2:0] {
    OP_LOAD_PT = 3'd0,
    OP_LOAD_CT = 3'd1,
    OP_CLEAR   = 3'd2,
    OP_PUSH    = 3'd3,
    OP_TEXT    = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    MODE_QUAGMIRE = 2'd0,
    MODE_BEAUFORT = 2'd1,
    MODE_PORTA    = 2'd2
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE    = 2'd0,
    CFG_VARIANT = 2'd1,
    CFG_DIR     = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [2:0]          op;
    logic [LETTER_W-1:0] position;
    logic [LETTER_W-1:0] letter;
  } in_item_t;

  typedef struct packed {
    logic [LETTER_W-1:0] out_letter;
    logic [1:0]          status;
  } out_item_t;

endpackage

FILE: rtl/autokey_cipher_engine.sv
`timescale 1ns / 1ps
// Autokey cipher engine: Quagmire/Vigenere, Beaufort and Porta with a key queue.
// An input transfer is captured in the input register; one pass of table lookups and mod-26
// adds and subtracts then feeds the result register. Throughput: one item per cycle while the
// output does not stall; an output stall holds a result-producing item in the input register.
// Reset: configuration zero, alphabets and inverses identity, key queue empty.
// The key queue storage itself is not cleared.
module autokey_cipher_engine #(
  parameter int unsigned MAX_PRIMER = akc_pkg::MAX_PRIMER_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  akc_pkg::in_item_t                    in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output akc_pkg::out_item_t                   out_data_o,
  input  logic                                 cfg_we_i,
  input  logic [akc_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [akc_pkg::CFG_DATA_W-1:0]       cfg_wdata_i
);
  import akc_pkg::*;

  localparam int unsigned PTR_W = (MAX_PRIMER > 1) ? $clog2(MAX_PRIMER) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_PRIMER + 1);
  localparam logic [CNT_W:0] MaxSum = (CNT_W + 1)'(MAX_PRIMER);

  typedef logic [LETTER_W-1:0] letter_t;

  function automatic letter_t add26(letter_t a, letter_t b);
    logic [LETTER_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (LETTER_W + 1)'(ALPHA_N)) begin
      s = s - (LETTER_W + 1)'(ALPHA_N);
    end
    return s[LETTER_W-1:0];
  endfunction

  function automatic letter_t sub26(letter_t a, letter_t b);
    logic [LETTER_W:0] s;
    s = {1'b0, a} - {1'b0, b};
    if (a < b) begin
      s = s + (LETTER_W + 1)'(ALPHA_N);
    end
    return s[LETTER_W-1:0];
  endfunction

  function automatic letter_t porta_map(letter_t x, letter_t k);
    letter_t shift;
    letter_t s;
    letter_t r;
    shift = {1'b0, k[LETTER_W-1:1]};
    if (x < letter_t'(HALF_N)) begin
      s = x + shift;
      if (s >= letter_t'(HALF_N)) begin
        s = s - letter_t'(HALF_N);
      end
      r = s + letter_t'(HALF_N);
    end else begin
      s = x - letter_t'(HALF_N);
      if (s < shift) begin
        r = s + letter_t'(HALF_N) - shift;
      end else begin
        r = s - shift;
      end
    end
    return r;
  endfunction

  logic [1:0] mode_q;
  logic       variant_q;
  logic       dir_q;

  logic       in_valid_q;
  in_item_t   in_q;

  logic       out_valid_q;
  out_item_t  out_q;

  letter_t    pt_alpha_q   [ALPHA_N];
  letter_t    ct_alpha_q   [ALPHA_N];
  letter_t    pt_inv_q     [ALPHA_N];
  letter_t    ct_inv_let_q [ALPHA_N];
  letter_t    ct_inv_key_q [ALPHA_N];

  letter_t    kq_mem [MAX_PRIMER];
  letter_t    kq_rdata_q;
  logic       kq_fwd_q;
  letter_t    kq_fwd_data_q;

  logic [PTR_W-1:0] head_q, head_d;
  logic [CNT_W-1:0] count_q, count_d;

  letter_t          let_f;
  letter_t          key;
  letter_t          inv_a;
  letter_t          inv_b;
  letter_t          idx;
  letter_t          res;
  letter_t          plain;
  logic [CNT_W:0]   tail_sum;
  logic [PTR_W-1:0] tail;
  logic             is_text;
  logic             is_push;
  logic             q_empty;
  logic             q_full;
  logic             produces;
  logic             out_free;
  logic             go;
  logic             in_take;
  logic             kq_we;
  letter_t          kq_wdata;
  logic             alpha_we;
  logic             pos_ok;
  out_item_t        result;

  assign let_f = (in_q.letter >= letter_t'(ALPHA_N)) ?
                 in_q.letter - letter_t'(ALPHA_N) : in_q.letter;
  assign key   = kq_fwd_q ? kq_fwd_data_q : kq_rdata_q;

  assign is_text  = in_q.op == OP_TEXT;
  assign is_push  = in_q.op == OP_PUSH;
  assign q_empty  = count_q == '0;
  assign q_full   = count_q >= CNT_W'(MAX_PRIMER);
  assign produces = is_text || (is_push && q_full);
  assign out_free = !out_valid_q || !out_stall_i;
  assign go       = in_valid_q && (!produces || out_free);
  assign in_stall_o = in_valid_q && !go;
  assign in_take  = in_valid_i && !in_stall_o;
  assign pos_ok   = in_q.position < letter_t'(ALPHA_N);
  assign alpha_we = go && pos_ok;

  assign tail_sum = {{(CNT_W + 1 - PTR_W){1'b0}}, head_q} + {1'b0, count_q};
  always_comb begin
    if (tail_sum >= MaxSum) begin
      tail = PTR_W'(tail_sum - MaxSum);
    end else begin
      tail = PTR_W'(tail_sum);
    end
  end

  always_comb begin
    inv_a = dir_q ? ct_inv_let_q[let_f] : pt_inv_q[let_f];
    inv_b = ct_inv_key_q[key];
    if (variant_q ^ dir_q) begin
      idx = sub26(inv_a, inv_b);
    end else begin
      idx = add26(inv_a, inv_b);
    end
    case (mode_q)
      MODE_BEAUFORT: res = sub26(key, let_f);
      MODE_PORTA:    res = porta_map(let_f, key);
      default:       res = dir_q ? pt_alpha_q[idx] : ct_alpha_q[idx];
    endcase
    plain = dir_q ? res : let_f;
  end

  always_comb begin
    head_d   = head_q;
    count_d  = count_q;
    kq_we    = 1'b0;
    kq_wdata = let_f;
    result   = '{out_letter: '0, status: ST_OK};
    if (go) begin
      case (in_q.op)
        OP_CLEAR: begin
          head_d  = '0;
          count_d = '0;
        end
        OP_PUSH: begin
          if (q_full) begin
            result.status = ST_FULL;
          end else begin
            kq_we   = 1'b1;
            count_d = count_q + CNT_W'(1);
          end
        end
        OP_TEXT: begin
          if (q_empty) begin
            result.status = ST_EMPTY;
          end else begin
            kq_we             = 1'b1;
            kq_wdata          = plain;
            result.out_letter = res;
            if (head_q == PTR_W'(MAX_PRIMER - 1)) begin
              head_d = '0;
            end else begin
              head_d = head_q + PTR_W'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= '0;
      variant_q <= 1'b0;
      dir_q     <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MODE:    mode_q    <= cfg_wdata_i[1:0];
        CFG_VARIANT: variant_q <= cfg_wdata_i[0];
        CFG_DIR:     dir_q     <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      head_q      <= '0;
      count_q     <= '0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (go) begin
        in_valid_q <= 1'b0;
      end
      if (go && produces) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
    if (go && produces) begin
      out_q <= result;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ALPHA_N; i++) begin
        pt_alpha_q[i]   <= letter_t'(i);
        ct_alpha_q[i]   <= letter_t'(i);
        pt_inv_q[i]     <= letter_t'(i);
        ct_inv_let_q[i] <= letter_t'(i);
        ct_inv_key_q[i] <= letter_t'(i);
      end
    end else if (alpha_we) begin
      if (in_q.op == OP_LOAD_PT) begin
        pt_alpha_q[in_q.position] <= let_f;
        pt_inv_q[let_f]           <= in_q.position;
      end else if (in_q.op == OP_LOAD_CT) begin
        ct_alpha_q[in_q.position] <= let_f;
        ct_inv_let_q[let_f]       <= in_q.position;
        ct_inv_key_q[let_f]       <= in_q.position;
      end
    end
  end

  // The key at the new head is fetched every cycle; a write to that entry is forwarded.
  always_ff @(posedge clk_i) begin
    if (kq_we) begin
      kq_mem[tail] <= kq_wdata;
    end
    kq_rdata_q    <= kq_mem[head_d];
    kq_fwd_q      <= kq_we && (tail == head_d);
    kq_fwd_data_q <= kq_wdata;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: tb/autokey_cipher_checker.sv
`timescale 1ns / 1ps
// Checker for the autokey cipher engine: mirrors its state, predicts and compares results.
module autokey_cipher_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  akc_pkg::in_item_t              in_data_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  akc_pkg::out_item_t             out_data_i,
  input  logic                           cfg_we_i,
  input  logic [akc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [akc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output int                             errors_o,
  output int                             pending_o,
  output int                             results_o
);
  import akc_pkg::*;

  logic [LETTER_W-1:0] pt_alpha [ALPHA_N];
  logic [LETTER_W-1:0] ct_alpha [ALPHA_N];
  logic [LETTER_W-1:0] pt_inv   [ALPHA_N];
  logic [LETTER_W-1:0] ct_inv   [ALPHA_N];
  logic [LETTER_W-1:0] key_ring [MAX_PRIMER_DEF];
  logic [4:0]          key_head;
  int                  key_count;
  logic [1:0]          mode_q;
  logic                variant_q;
  logic                decipher_q;
  out_item_t           letters_due [$];
  int                  n_errors;
  int                  n_results;

  task automatic reset_cipher();
    for (int i = 0; i < ALPHA_N; i++) begin
      pt_alpha[i] = LETTER_W'(i);
      ct_alpha[i] = LETTER_W'(i);
      pt_inv[i]   = LETTER_W'(i);
      ct_inv[i]   = LETTER_W'(i);
    end
    key_head   = '0;
    key_count  = 0;
    mode_q     = MODE_QUAGMIRE;
    variant_q  = 1'b0;
    decipher_q = 1'b0;
    letters_due.delete();
  endtask

  // Applies one input transfer to the mirrored state and queues the result it causes.
  task automatic cipher_letter(input in_item_t it);
    int        x;
    int        k;
    int        a;
    int        b;
    int        idx;
    int        res;
    int        plain;
    out_item_t due;
    x   = (it.letter >= ALPHA_N) ? int'(it.letter) - ALPHA_N : int'(it.letter);
    due = '0;
    case (it.op)
      OP_LOAD_PT: begin
        if (it.position < ALPHA_N) begin
          pt_alpha[it.position] = LETTER_W'(x);
          pt_inv[x]             = it.position;
        end
      end
      OP_LOAD_CT: begin
        if (it.position < ALPHA_N) begin
          ct_alpha[it.position] = LETTER_W'(x);
          ct_inv[x]             = it.position;
        end
      end
      OP_CLEAR: begin
        key_head  = '0;
        key_count = 0;
      end
      OP_PUSH: begin
        if (key_count >= MAX_PRIMER_DEF) begin
          due.status = ST_FULL;
          letters_due.push_back(due);
        end else begin
          key_ring[5'(key_head + key_count)] = LETTER_W'(x);
          key_count++;
        end
      end
      OP_TEXT: begin
        if (key_count == 0) begin
          due.status = ST_EMPTY;
          letters_due.push_back(due);
        end else begin
          k = key_ring[key_head];
          if (mode_q == MODE_BEAUFORT) begin
            res = (k + ALPHA_N - x) % ALPHA_N;
          end else if (mode_q == MODE_PORTA) begin
            if (x < HALF_N) begin
              res = (x + k / 2) % HALF_N + HALF_N;
            end else begin
              res = (x - HALF_N + ALPHA_N - k / 2) % HALF_N;
            end
          end else if (!decipher_q) begin
            a   = pt_inv[x];
            b   = ct_inv[k];
            idx = variant_q ? (a + ALPHA_N - b) % ALPHA_N : (a + b) % ALPHA_N;
            res = ct_alpha[idx];
          end else begin
            a   = ct_inv[x];
            b   = ct_inv[k];
            idx = variant_q ? (a + b) % ALPHA_N : (a + ALPHA_N - b) % ALPHA_N;
            res = pt_alpha[idx];
          end
          plain = decipher_q ? res : x;
          key_ring[5'(key_head + key_count)] = LETTER_W'(plain);
          key_head = key_head + 5'd1;
          due.out_letter = LETTER_W'(res);
          due.status     = ST_OK;
          letters_due.push_back(due);
        end
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_cipher();
      n_errors  = 0;
      n_results = 0;
      errors_o  <= 0;
      pending_o <= 0;
      results_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MODE:    mode_q     = cfg_wdata_i[1:0];
          CFG_VARIANT: variant_q  = cfg_wdata_i[0];
          CFG_DIR:     decipher_q = cfg_wdata_i[0];
          default: begin
          end
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        n_results++;
        if (letters_due.size() == 0) begin
          if (n_errors < 10) begin
            $display("%0t: result with nothing pending: letter %0d status %0d",
                     $realtime, out_data_i.out_letter, out_data_i.status);
          end
          n_errors++;
        end else if (out_data_i.out_letter !== letters_due[0].out_letter ||
                     out_data_i.status !== letters_due[0].status) begin
          if (n_errors < 10) begin
            $display("%0t: mismatch: expected letter %0d status %0d, got letter %0d status %0d",
                     $realtime, letters_due[0].out_letter, letters_due[0].status,
                     out_data_i.out_letter, out_data_i.status);
          end
          n_errors++;
          void'(letters_due.pop_front());
        end else begin
          void'(letters_due.pop_front());
        end
      end
      if (in_valid_i && !in_stall_i) begin
        cipher_letter(in_data_i);
      end
      errors_o  <= n_errors;
      pending_o <= letters_due.size();
      results_o <= n_results;
    end
  end

endmodule

FILE: tb/tb_autokey_cipher_engine.sv
`timescale 1ns / 1ps
// Testbench top for the autokey cipher engine: stimulus, stall patterns and verdict.
module tb_autokey_cipher_engine;
  import akc_pkg::*;

  localparam int IDLE_LIMIT  = 3000;
  localparam int HOLD_CYCLES = 200;
  localparam int N_SETTINGS  = 16;
  localparam int PHASE_ITEMS = 55;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int errors;
  int pending;
  int results;
  int send_idle = 0;
  int recv_idle = 0;
  int hold_gen  = 0;
  int n_items   = 0;
  int n_settings = 0;

  autokey_cipher_engine u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  autokey_cipher_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .errors_o    (errors),
    .pending_o   (pending),
    .results_o   (results)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The receiver stalls at random, and once holds off for a long stretch on request.
  initial begin
    int hold_seen;
    hold_seen = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_gen != hold_seen) begin
        hold_seen = hold_gen;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic in_item_t make_item(input logic [2:0] op, input int pos, input int letter);
    in_item_t it;
    it.op       = op;
    it.position = LETTER_W'(pos);
    it.letter   = LETTER_W'(letter);
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_items++;
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // Loads a full keyed alphabet as a random permutation.
  task automatic load_alphabet(input op_e op);
    int perm [ALPHA_N];
    int j;
    int t;
    for (int i = 0; i < ALPHA_N; i++) perm[i] = i;
    for (int i = ALPHA_N - 1; i > 0; i--) begin
      j       = $urandom_range(i);
      t       = perm[i];
      perm[i] = perm[j];
      perm[j] = t;
    end
    for (int i = 0; i < ALPHA_N; i++) send_item(make_item(op, i, perm[i]));
  endtask

  // One message: a primer, occasionally a full queue and overflow, then the text letters.
  task automatic run_session();
    int seed_len;
    int text_len;
    if ($urandom_range(5) != 0) send_item(make_item(OP_CLEAR, $urandom_range(31), 0));
    if ($urandom_range(7) == 0) send_item(make_item(OP_TEXT, 0, $urandom_range(31)));
    seed_len = ($urandom_range(9) == 0) ? MAX_PRIMER_DEF : $urandom_range(1, 8);
    repeat (seed_len) send_item(make_item(OP_PUSH, $urandom_range(31), $urandom_range(31)));
    if (seed_len == MAX_PRIMER_DEF) begin
      repeat ($urandom_range(1, 3)) begin
        send_item(make_item(OP_PUSH, $urandom_range(31), $urandom_range(31)));
      end
    end
    text_len = $urandom_range(4, 24);
    repeat (text_len) begin
      if ($urandom_range(11) == 0) begin
        send_item(make_item(3'($urandom_range(7)), $urandom_range(31), $urandom_range(31)));
      end
      send_item(make_item(OP_TEXT, $urandom_range(31), $urandom_range(31)));
    end
  endtask

  initial begin
    int phase_start;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_idx   <= CFG_MODE;
    cfg_wdata <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(make_item(OP_TEXT, 0, 0));
    send_item(make_item(OP_PUSH, 0, 0));
    send_item(make_item(OP_PUSH, 0, 25));
    send_item(make_item(OP_PUSH, 31, 31));
    send_item(make_item(OP_TEXT, 0, 0));
    send_item(make_item(OP_TEXT, 0, 25));
    send_item(make_item(OP_TEXT, 31, 31));
    send_item(make_item(OP_LOAD_PT, 31, 3));
    send_item(make_item(OP_LOAD_CT, 26, 7));
    send_item(make_item(OP_LOAD_PT, 0, 25));
    send_item(make_item(OP_LOAD_CT, 25, 0));
    send_item(make_item(OP_LOAD_CT, 3, 29));
    send_item(make_item(3'(5), 31, 31));
    send_item(make_item(3'(6), 0, 0));
    send_item(make_item(3'(7), 31, 31));
    send_item(make_item(OP_TEXT, 0, 13));
    send_item(make_item(OP_TEXT, 0, 12));
    send_item(make_item(OP_CLEAR, 0, 0));
    send_item(make_item(OP_TEXT, 0, 12));
    send_item(make_item(OP_PUSH, 0, 26));
    send_item(make_item(OP_TEXT, 0, 12));

    for (int ph = 0; ph < N_SETTINGS; ph++) begin
      wait_for_results();
      if (ph == 0) begin
        send_idle <= 25;
        recv_idle <= 82;
      end else if (ph == 5) begin
        send_idle <= 82;
        recv_idle <= 25;
      end else if (ph == 10) begin
        send_idle <= 0;
        recv_idle <= 0;
      end
      write_reg(CFG_MODE, 2'(ph % 4));
      write_reg(CFG_VARIANT, {1'($urandom_range(1)), 1'((ph / 4) % 2)});
      write_reg(CFG_DIR, {1'($urandom_range(1)), 1'(ph / 8)});
      cfg_we <= 1'b0;
      n_settings++;
      if (ph == 11) hold_gen <= hold_gen + 1;
      phase_start = n_items;
      if (ph % 4 == 0) begin
        load_alphabet(OP_LOAD_PT);
      end else if (ph % 4 == 2) begin
        load_alphabet(OP_LOAD_CT);
      end
      while (n_items - phase_start < PHASE_ITEMS) run_session();
    end

    wait_for_results();
    $display("Sent %0d items over %0d register settings (all four mode codes, both signs",
             n_items, n_settings);
    $display("and directions) and checked %0d results under varied stall patterns.", results);
    if (errors == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
